>>> rtl/saj_pkg.sv
package saj_pkg;

  localparam int unsigned Entries = 32;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam int unsigned AddrW = 48;
  localparam int unsigned HandleW = 8;
  localparam int unsigned LevelW = 8;
  localparam logic [LevelW-1:0] LevelMax = '1;
  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    FUNC_ENTER  = 3'd0,
    FUNC_TRACK  = 3'd1,
    FUNC_FORGET = 3'd2,
    FUNC_DRAIN  = 3'd3,
    FUNC_EXIT   = 3'd4,
    FUNC_CLEAR  = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_UPDATED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_SATURATED = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]         func;
    logic [AddrW-1:0]   address;
    logic [HandleW-1:0] release_handle;
    logic               is_owner;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [AddrW-1:0]   out_address;
    logic [HandleW-1:0] out_handle;
    logic [2:0]         status;
    logic [5:0]         entries_held;
    logic [LevelW-1:0]  level_now;
    logic               last;
  } out_item_t;

  // Classified command handed from the front to the back part.
  typedef struct packed {
    logic               needs_scan;
    logic               ignore;
    func_e              func;
    logic [AddrW-1:0]   address;
    logic [HandleW-1:0] handle;
  } cmd_t;

endpackage

>>> rtl/scoped_allocation_journal_top.sv
// Scoped allocation journal.
// Input channel in_valid_i / in_stall_o carries one command transaction
// (in_data_i). Output channel out_valid_o / out_stall_i carries result
// transactions (out_data_o); every command ends in one status transaction
// with last set, and a drain first sends one release request per entry
// drained. A transaction moves when valid is high and stall is low.
// A front part classifies commands into a two-entry queue; the back part
// executes them one at a time against a 32-entry table held in memory,
// read one entry per cycle while no drained entry waits for the output.
// Enter, clear, ignored commands and exit at level 0 or 1 do not walk the
// table; exit above level 1, track and forget walk it once, and drain
// walks it twice, since it first counts the survivors and then walks the
// table again to send the releases; an output stall can hold a drain.
// The table walks set the rate: one command finishes before the next starts.
// Reset clears the entry count, the level and all queues; table contents
// need no clearing. When the receiver stalls, the back part holds its
// result and the queue fills, after which in_stall_o rises.
module scoped_allocation_journal_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  saj_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output saj_pkg::out_item_t out_data_o
);

  logic          cmd_valid, cmd_pop;
  saj_pkg::cmd_t cmd;

  saj_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  saj_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop),
    .cmd_i(cmd), .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

>>> rtl/saj_front.sv
module saj_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  saj_pkg::in_item_t in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i,
  output saj_pkg::cmd_t    cmd_o
);

  saj_pkg::cmd_t q_mem [saj_pkg::QDepth];
  logic [0:0] wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  saj_pkg::cmd_t cls;
  logic push;

  // Classification: pure input checks, no state needed.
  always_comb begin
    cls.func       = saj_pkg::func_e'(in_data_i.func);
    cls.address    = in_data_i.address;
    cls.handle     = in_data_i.release_handle;
    cls.ignore     = 1'b0;
    cls.needs_scan = 1'b0;
    case (in_data_i.func)
      saj_pkg::FUNC_TRACK: begin
        cls.ignore = !in_data_i.is_owner || in_data_i.address == '0 ||
                     in_data_i.release_handle == '0;
      end
      saj_pkg::FUNC_FORGET: cls.ignore = in_data_i.address == '0;
      saj_pkg::FUNC_ENTER, saj_pkg::FUNC_DRAIN, saj_pkg::FUNC_EXIT,
      saj_pkg::FUNC_CLEAR: cls.ignore = 1'b0;
      default: cls.ignore = 1'b1;
    endcase
    cls.needs_scan = !cls.ignore && (in_data_i.func == saj_pkg::FUNC_TRACK ||
                     in_data_i.func == saj_pkg::FUNC_FORGET ||
                     in_data_i.func == saj_pkg::FUNC_DRAIN);
  end

  assign in_stall_o  = cnt_q == 2'(saj_pkg::QDepth);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = q_mem[rd_q];

  always_comb begin
    wr_d  = wr_q + 1'(push);
    rd_d  = rd_q + 1'(cmd_pop_i);
    cnt_d = cnt_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/saj_back.sv
module saj_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  saj_pkg::cmd_t     cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output saj_pkg::out_item_t out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FIX, S_MOVE, S_COUNT, S_DRAIN, S_LOWER, S_EMIT
  } state_e;

  localparam int unsigned E = saj_pkg::Entries;
  localparam int unsigned IW = saj_pkg::IdxW;
  localparam int unsigned CW = saj_pkg::CntW;

  logic [saj_pkg::AddrW-1:0]   mem_addr [E];
  logic [saj_pkg::HandleW-1:0] mem_hdl  [E];
  logic [saj_pkg::LevelW-1:0]  mem_lvl  [E];

  state_e state_q;
  saj_pkg::cmd_t cmd_q;
  logic [CW-1:0] fill_q, k_q, w_q, hit_q, keep_q;
  logic [CW-1:0] k_prev;
  logic          found_q;
  logic [saj_pkg::LevelW-1:0] level_q;
  logic [saj_pkg::AddrW-1:0]   rd_addr_q;
  logic [saj_pkg::HandleW-1:0] rd_hdl_q;
  logic [saj_pkg::LevelW-1:0]  rd_lvl_q;
  logic rd_ok_q;
  logic [2:0] status_q;
  logic out_valid_q;
  saj_pkg::out_item_t out_q, out_d;
  logic out_free;
  logic drain_hit, drain_hold, drain_emit, out_load;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cmd_pop_o   = state_q == S_IDLE && cmd_valid_i;
  assign k_prev      = k_q - 1'b1;

  // A drained entry waits in rd_* while the output register is still busy.
  assign drain_hit  = state_q == S_DRAIN && rd_ok_q && rd_lvl_q >= level_q;
  assign drain_hold = drain_hit && !out_free;
  assign drain_emit = drain_hit && out_free;
  assign out_load   = drain_emit || (state_q == S_EMIT && out_free);

  always_comb begin
    out_d           = '0;
    out_d.level_now = level_q;
    if (state_q == S_DRAIN) begin
      out_d.kind         = 1'b1;
      out_d.out_address  = rd_addr_q;
      out_d.out_handle   = rd_hdl_q;
      out_d.entries_held = 6'(keep_q);
    end else begin
      out_d.status       = status_q;
      out_d.entries_held = 6'(fill_q);
      out_d.last         = 1'b1;
    end
  end

  // Memories are read one entry a cycle, unless a drained entry is held, with a
  // registered read; rd_ok_q marks that rd_* holds entry k_q - 1.
  always_ff @(posedge clk_i) begin
    if (k_q < fill_q && !drain_hold) begin
      rd_addr_q <= mem_addr[k_q[IW-1:0]];
      rd_hdl_q  <= mem_hdl[k_q[IW-1:0]];
      rd_lvl_q  <= mem_lvl[k_q[IW-1:0]];
    end
    if (state_q == S_FIX) begin
      if (cmd_q.func == saj_pkg::FUNC_TRACK) begin
        if (found_q) begin
          mem_hdl[hit_q[IW-1:0]] <= cmd_q.handle;
          mem_lvl[hit_q[IW-1:0]] <= level_q;
        end else if (fill_q < CW'(E)) begin
          mem_addr[fill_q[IW-1:0]] <= cmd_q.address;
          mem_hdl[fill_q[IW-1:0]]  <= cmd_q.handle;
          mem_lvl[fill_q[IW-1:0]]  <= level_q;
        end
      end
    end
    if (state_q == S_MOVE) begin
      mem_addr[hit_q[IW-1:0]] <= rd_addr_q;
      mem_hdl[hit_q[IW-1:0]]  <= rd_hdl_q;
      mem_lvl[hit_q[IW-1:0]]  <= rd_lvl_q;
    end
    if (state_q == S_DRAIN && rd_ok_q && rd_lvl_q < level_q) begin
      mem_addr[w_q[IW-1:0]] <= rd_addr_q;
      mem_hdl[w_q[IW-1:0]]  <= rd_hdl_q;
      mem_lvl[w_q[IW-1:0]]  <= rd_lvl_q;
    end
    if (state_q == S_LOWER && rd_ok_q && rd_lvl_q >= level_q) begin
      mem_lvl[k_prev[IW-1:0]] <= level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      fill_q      <= '0;
      level_q     <= '0;
      k_q         <= '0;
      w_q         <= '0;
      hit_q       <= '0;
      keep_q      <= '0;
      found_q     <= 1'b0;
      rd_ok_q     <= 1'b0;
      status_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q    <= cmd_i;
            k_q      <= '0;
            w_q      <= '0;
            keep_q   <= '0;
            found_q  <= 1'b0;
            rd_ok_q  <= 1'b0;
            if (cmd_i.ignore ||
                (cmd_i.func == saj_pkg::FUNC_TRACK && level_q == '0)) begin
              status_q <= saj_pkg::ST_IGNORED;
              state_q  <= S_EMIT;
            end else if (cmd_i.needs_scan) begin
              status_q <= saj_pkg::ST_DONE;
              state_q  <= cmd_i.func == saj_pkg::FUNC_DRAIN ? S_COUNT : S_SCAN;
            end else begin
              status_q <= (cmd_i.func == saj_pkg::FUNC_ENTER &&
                           level_q == saj_pkg::LevelMax) ?
                          saj_pkg::ST_SATURATED : saj_pkg::ST_DONE;
              case (cmd_i.func)
                saj_pkg::FUNC_ENTER: begin
                  if (level_q != saj_pkg::LevelMax) level_q <= level_q + 1'b1;
                end
                saj_pkg::FUNC_EXIT: begin
                  if (level_q <= 8'd1) begin
                    fill_q <= '0; level_q <= '0;
                  end
                end
                saj_pkg::FUNC_CLEAR: fill_q <= '0;
                default: ;
              endcase
              // Exit above level 1 walks the table to lower the top frame.
              state_q <= (cmd_i.func == saj_pkg::FUNC_EXIT && level_q > 8'd1) ?
                         S_LOWER : S_EMIT;
            end
          end
        end
        S_SCAN: begin
          // Search all entries; the last hit seen is the newest.
          if (k_q < fill_q) k_q <= k_q + 1'b1;
          rd_ok_q <= k_q < fill_q;
          if (rd_ok_q && rd_addr_q == cmd_q.address) begin
            found_q <= 1'b1;
            hit_q   <= k_q - 1'b1;
          end
          if (!(k_q < fill_q) && !rd_ok_q) state_q <= S_FIX;
        end
        S_FIX: begin
          k_q     <= fill_q - 1'b1;
          rd_ok_q <= 1'b0;
          if (cmd_q.func == saj_pkg::FUNC_TRACK) begin
            if (found_q) status_q <= saj_pkg::ST_UPDATED;
            else if (fill_q < CW'(E)) fill_q <= fill_q + 1'b1;
            else status_q <= saj_pkg::ST_FULL;
            state_q <= S_EMIT;
          end else if (!found_q) begin
            status_q <= saj_pkg::ST_NOT_FOUND;
            state_q  <= S_EMIT;
          end else begin
            // rd_* still holds the last entry, read at the end of the scan.
            state_q <= S_MOVE;
          end
        end
        S_MOVE: begin
          fill_q  <= fill_q - 1'b1;
          state_q <= S_EMIT;
        end
        S_COUNT: begin
          // Count the survivors first; every release reports the final count.
          rd_ok_q <= k_q < fill_q;
          if (rd_ok_q && rd_lvl_q < level_q) keep_q <= keep_q + 1'b1;
          if (k_q < fill_q) begin
            k_q <= k_q + 1'b1;
          end else if (!rd_ok_q) begin
            k_q     <= '0;
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!drain_hold) begin
            if (rd_ok_q && rd_lvl_q < level_q) w_q <= w_q + 1'b1;
            if (k_q < fill_q) k_q <= k_q + 1'b1;
            rd_ok_q <= k_q < fill_q;
            if (!(k_q < fill_q) && !rd_ok_q) begin
              fill_q  <= w_q;
              state_q <= S_EMIT;
            end
          end
        end
        S_LOWER: begin
          if (k_q < fill_q) k_q <= k_q + 1'b1;
          rd_ok_q <= k_q < fill_q;
          if (!(k_q < fill_q) && !rd_ok_q) begin
            level_q <= level_q - 1'b1;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/saj_checker.sv
module saj_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input saj_pkg::out_item_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind |-> !out_data_o.last && out_data_o.status == '0)
    else $error("release request malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.entries_held <= 6'(saj_pkg::Entries))
    else $error("entry count too high");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last && !out_data_o.kind |-> out_data_o.out_address == '0)
    else $error("status carries address");

endmodule

bind scoped_allocation_journal_top saj_checker u_chk (.*);
